// ===== rtl/core/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants of the RGB 2x2 box downsampler: payload structs,
// dimension limits, line buffer geometry and configuration register indexes.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WEFF_W = COL_W + 1;
  localparam int HEFF_W = ROW_W + 1;

  localparam int CHAN_W = 8;
  localparam int PSUM_W = CHAN_W + 1;
  localparam int TSUM_W = CHAN_W + 2;
  localparam int LINE_W = 3 * PSUM_W;

  localparam int DIM_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } in_pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              frame_end;
  } out_pixel_t;

  typedef struct packed {
    logic [PSUM_W-1:0] red;
    logic [PSUM_W-1:0] green;
    logic [PSUM_W-1:0] blue;
  } pair_sum_t;

endpackage

// ===== rtl/core/rbd_ram.sv =====
// ----------------------------------------------------------------------------
// rbd_ram
// Generic simple dual-port RAM with one write port and one registered read
// port. Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module rbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/rgb_box_downsample_2x2_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_box_downsample_2x2_unit
// Pipeline: stage one registers the pair sum and line buffer read when the
// pixel that completes a 2x2 block is accepted; the output register follows.
// Throughput: one source pixel per clock while stage one can drain to output.
// Reset: source width and height return to 256 and the position counters to
// zero; the line buffer is not cleared, since every entry is written before
// it is read.
// ----------------------------------------------------------------------------
module rgb_box_downsample_2x2_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rbd_pkg::in_pixel_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rbd_pkg::out_pixel_t              out_data,
  input  logic                             cfg_we,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rbd_pkg::DIM_W-1:0]        cfg_wdata
);

  import rbd_pkg::*;

  logic [DIM_W-1:0]  source_width_r, source_width_nxt;
  logic [DIM_W-1:0]  source_height_r, source_height_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  in_pixel_t         left_pixel_r, left_pixel_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  pair_sum_t         s1_psum_r, s1_psum_nxt;
  logic              s1_last_r, s1_last_nxt;

  logic              out_valid_r, out_valid_nxt;
  out_pixel_t        out_data_r, out_data_nxt;

  logic [WEFF_W-1:0] w_eff, used_w, col_inc;
  logic [HEFF_W-1:0] h_eff, used_h, row_inc;
  logic              accept, out_free, in_range, odd_col, odd_row;
  logic              line_we, line_re;
  pair_sum_t         psum, prev_sum;
  logic [LINE_W-1:0] line_rdata;
  logic [TSUM_W-1:0] tot_r, tot_g, tot_b;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (source_width_r < DIM_W'(2)) begin
      w_eff = WEFF_W'(2);
    end else if (32'(source_width_r) > MAX_WIDTH) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(source_width_r);
    end
    if (source_height_r < DIM_W'(2)) begin
      h_eff = HEFF_W'(2);
    end else if (32'(source_height_r) > MAX_HEIGHT) begin
      h_eff = HEFF_W'(MAX_HEIGHT);
    end else begin
      h_eff = HEFF_W'(source_height_r);
    end
  end

  assign used_w   = {w_eff[WEFF_W-1:1], 1'b0};
  assign used_h   = {h_eff[HEFF_W-1:1], 1'b0};
  assign col_inc  = {1'b0, col_r} + WEFF_W'(1);
  assign row_inc  = {1'b0, row_r} + HEFF_W'(1);
  assign in_range = ({1'b0, col_r} < used_w) && ({1'b0, row_r} < used_h);
  assign odd_col  = col_r[0];
  assign odd_row  = row_r[0];

  assign psum.red   = {1'b0, left_pixel_r.red_in} + {1'b0, in_data.red_in};
  assign psum.green = {1'b0, left_pixel_r.green_in} + {1'b0, in_data.green_in};
  assign psum.blue  = {1'b0, left_pixel_r.blue_in} + {1'b0, in_data.blue_in};

  assign line_we = accept && in_range && odd_col && !odd_row;
  assign line_re = accept && in_range && odd_col && odd_row;

  rbd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (col_r[COL_W-1:1]),
    .wdata (psum),
    .re    (line_re),
    .raddr (col_r[COL_W-1:1]),
    .rdata (line_rdata)
  );

  assign prev_sum = line_rdata;
  assign tot_r = {1'b0, prev_sum.red} + {1'b0, s1_psum_r.red};
  assign tot_g = {1'b0, prev_sum.green} + {1'b0, s1_psum_r.green};
  assign tot_b = {1'b0, prev_sum.blue} + {1'b0, s1_psum_r.blue};

  always_comb begin
    source_width_nxt  = source_width_r;
    source_height_nxt = source_height_r;
    col_nxt           = col_r;
    row_nxt           = row_r;
    left_pixel_nxt    = left_pixel_r;
    s1_valid_nxt      = s1_valid_r;
    s1_psum_nxt       = s1_psum_r;
    s1_last_nxt       = s1_last_r;
    out_valid_nxt     = out_valid_r;
    out_data_nxt      = out_data_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_WIDTH:  source_width_nxt = cfg_wdata;
        CFG_SOURCE_HEIGHT: source_height_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (out_free) begin
      out_valid_nxt = s1_valid_r;
      if (s1_valid_r) begin
        out_data_nxt.red_out   = tot_r[TSUM_W-1:2];
        out_data_nxt.green_out = tot_g[TSUM_W-1:2];
        out_data_nxt.blue_out  = tot_b[TSUM_W-1:2];
        out_data_nxt.frame_end = s1_last_r;
      end
      s1_valid_nxt = 1'b0;
    end

    if (accept) begin
      if (in_range && !odd_col) begin
        left_pixel_nxt = in_data;
      end
      if (line_re) begin
        s1_valid_nxt = 1'b1;
        s1_psum_nxt  = psum;
        s1_last_nxt  = (col_inc == used_w) && (row_inc == used_h);
      end
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        if (row_inc >= h_eff) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_inc[ROW_W-1:0];
        end
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_width_r  <= DIM_RESET;
      source_height_r <= DIM_RESET;
      col_r           <= '0;
      row_r           <= '0;
      left_pixel_r    <= '0;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      source_width_r  <= source_width_nxt;
      source_height_r <= source_height_nxt;
      col_r           <= col_nxt;
      row_r           <= row_nxt;
      left_pixel_r    <= left_pixel_nxt;
      s1_valid_r      <= s1_valid_nxt;
      out_valid_r     <= out_valid_nxt;
    end
    s1_psum_r  <= s1_psum_nxt;
    s1_last_r  <= s1_last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== test/box_average_checker.sv =====
// ----------------------------------------------------------------------------
// box_average_checker
// Watches the pixel, result and register ports of the 2x2 box downsampler,
// predicts every averaged pixel from the accepted source pixels and compares
// each accepted result, as a whole, with the oldest prediction.
// ----------------------------------------------------------------------------
module box_average_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  rbd_pkg::in_pixel_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  rbd_pkg::out_pixel_t           out_data,
  input  logic                          cfg_we,
  input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbd_pkg::DIM_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            outstanding
);

  import rbd_pkg::*;

  logic [DIM_W-1:0] src_w;
  logic [DIM_W-1:0] src_h;
  logic [DIM_W-1:0] col;
  logic [DIM_W-1:0] row;
  in_pixel_t        left_hold;
  pair_sum_t        line_sums [LINE_DEPTH];
  out_pixel_t       expected_pixels [$];
  int               failures;

  function automatic logic [DIM_W-1:0] bounded_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
    if (v < DIM_W'(2)) return DIM_W'(2);
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic accumulate_pixel(input in_pixel_t px);
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [DIM_W-1:0]  used_w;
    logic [DIM_W-1:0]  used_h;
    pair_sum_t         pair;
    pair_sum_t         above;
    logic [TSUM_W-1:0] tr;
    logic [TSUM_W-1:0] tg;
    logic [TSUM_W-1:0] tb;
    out_pixel_t        avg;
    w      = bounded_dim(src_w, DIM_W'(MAX_WIDTH));
    h      = bounded_dim(src_h, DIM_W'(MAX_HEIGHT));
    used_w = {w[DIM_W-1:1], 1'b0};
    used_h = {h[DIM_W-1:1], 1'b0};
    if (col < used_w && row < used_h) begin
      if (!col[0]) begin
        left_hold = px;
      end else begin
        pair.red   = PSUM_W'(left_hold.red_in) + PSUM_W'(px.red_in);
        pair.green = PSUM_W'(left_hold.green_in) + PSUM_W'(px.green_in);
        pair.blue  = PSUM_W'(left_hold.blue_in) + PSUM_W'(px.blue_in);
        if (!row[0]) begin
          line_sums[col[COL_W-1:1]] = pair;
        end else begin
          above = line_sums[col[COL_W-1:1]];
          tr = TSUM_W'(above.red) + TSUM_W'(pair.red);
          tg = TSUM_W'(above.green) + TSUM_W'(pair.green);
          tb = TSUM_W'(above.blue) + TSUM_W'(pair.blue);
          avg.red_out   = tr[TSUM_W-1:2];
          avg.green_out = tg[TSUM_W-1:2];
          avg.blue_out  = tb[TSUM_W-1:2];
          avg.frame_end = (col == used_w - 1) && (row == used_h - 1);
          expected_pixels.push_back(avg);
        end
      end
    end
    if (col + 1 >= w) begin
      col = '0;
      row = (row + 1 >= h) ? '0 : row + DIM_W'(1);
    end else begin
      col = col + DIM_W'(1);
    end
  endtask

  always @(posedge clk) begin
    out_pixel_t want;
    if (!rst_n) begin
      src_w     = DIM_RESET;
      src_h     = DIM_RESET;
      col       = '0;
      row       = '0;
      left_hold = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SOURCE_WIDTH) src_w = cfg_wdata;
        else if (cfg_index == CFG_SOURCE_HEIGHT) src_h = cfg_wdata;
      end
      if (in_valid && !in_stall) accumulate_pixel(in_data);
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected output pixel: r=%0d g=%0d b=%0d end=%0d",
                     out_data.red_out, out_data.green_out, out_data.blue_out,
                     out_data.frame_end);
        end else begin
          want = expected_pixels.pop_front();
          if (out_data !== want) begin
            failures++;
            if (failures <= 10)
              $display("pixel mismatch: expected r=%0d g=%0d b=%0d end=%0d,",
                       want.red_out, want.green_out, want.blue_out, want.frame_end,
                       " got r=%0d g=%0d b=%0d end=%0d",
                       out_data.red_out, out_data.green_out, out_data.blue_out,
                       out_data.frame_end);
          end
        end
      end
    end
    outstanding <= expected_pixels.size();
    fail_count  <= failures;
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the 2x2 box downsampler with source frames of many sizes, including
// the reset dimensions and clamped and odd dimensions, under changing idle
// patterns on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import rbd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_pixel_t            in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_pixel_t           out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_wdata;

  int check_failures;
  int results_outstanding;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left = 0;
  logic hold_req;
  logic hold_done = 1'b0;
  int cycle_count = 0;

  rgb_box_downsample_2x2_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  box_average_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (check_failures),
    .outstanding (results_outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver holds off once for a long stretch so that the block fills up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic in_pixel_t mk_pixel(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    in_pixel_t px;
    px.red_in   = r;
    px.green_in = g;
    px.blue_in  = b;
    return px;
  endfunction

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic in_pixel_t rand_pixel();
    return mk_pixel(rand_channel(), rand_channel(), rand_channel());
  endfunction

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  task automatic send_pixel(input in_pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SOURCE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_SOURCE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_frame(input logic [DIM_W-1:0] wr_w, input logic [DIM_W-1:0] wr_h,
                           input int npix);
    write_dims(wr_w, wr_h);
    repeat (npix) send_pixel(rand_pixel());
    settle();
  endtask

  task automatic random_frames(input int budget);
    int sent;
    int eff_w;
    int eff_h;
    logic [DIM_W-1:0] wr_w;
    logic [DIM_W-1:0] wr_h;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(9))
        0: begin
          eff_w = 2;
          wr_w  = DIM_W'($urandom_range(1));
        end
        1: begin
          eff_w = 2 * $urandom_range(1, 6) + 1;
          wr_w  = DIM_W'(eff_w);
        end
        default: begin
          eff_w = $urandom_range(2, 16);
          wr_w  = DIM_W'(eff_w);
        end
      endcase
      case ($urandom_range(9))
        0: begin
          eff_h = 2;
          wr_h  = DIM_W'($urandom_range(1));
        end
        1: begin
          eff_h = 2 * $urandom_range(1, 3) + 1;
          wr_h  = DIM_W'(eff_h);
        end
        default: begin
          eff_h = $urandom_range(2, 8);
          wr_h  = DIM_W'(eff_h);
        end
      endcase
      run_frame(wr_w, wr_h, eff_w * eff_h);
      sent += eff_w * eff_h;
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SOURCE_WIDTH;
    cfg_wdata     = '0;
    send_idle_pct = 16;
    recv_idle_pct = 88;
    hold_req      = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One row at the reset dimensions, then a height change in the middle of
    // the frame so that the second row completes the blocks and ends it.
    repeat (256) send_pixel(rand_pixel());
    settle();
    write_dims(DIM_W'(256), DIM_W'(2));
    repeat (256) send_pixel(rand_pixel());
    settle();

    // A row counter already past the new last row wraps at the next row.
    write_dims(DIM_W'(4), DIM_W'(4));
    repeat (12) send_pixel(rand_pixel());
    settle();
    write_dims(DIM_W'(4), DIM_W'(2));
    repeat (4) send_pixel(rand_pixel());
    settle();

    // Clamped width, saturated and empty blocks.
    write_dims(DIM_W'(0), DIM_W'(2));
    repeat (4) send_pixel(mk_pixel(8'd255, 8'd255, 8'd255));
    repeat (4) send_pixel(mk_pixel(8'd0, 8'd0, 8'd0));
    settle();
    // Odd width and height drop the last column and row.
    run_frame(DIM_W'(3), DIM_W'(3), 9);
    // Clamped height and floor rounding of the sums.
    write_dims(DIM_W'(2), DIM_W'(1));
    send_pixel(mk_pixel(8'd255, 8'd1, 8'd0));
    send_pixel(mk_pixel(8'd255, 8'd2, 8'd3));
    send_pixel(mk_pixel(8'd255, 8'd0, 8'd3));
    send_pixel(mk_pixel(8'd254, 8'd0, 8'd1));
    settle();

    random_frames(90);

    set_idling(88, 16);
    random_frames(90);

    set_idling(0, 0);
    hold_req <= 1'b1;
    run_frame(DIM_W'(16), DIM_W'(8), 128);
    random_frames(90);

    settle();
    if (check_failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
